// File: src/rti_pkg.sv
package rti_pkg;

  localparam int FRAC_BITS = 16;
  localparam int TAG_BITS  = 16;

  localparam int X_W  = 32;          // coordinate
  localparam int E_W  = X_W + 1;     // edge / offset
  localparam int PP_W = 2 * E_W;     // one cross product term
  localparam int P_W  = PP_W + 1;    // cross product component
  localparam int LO_W = 34;          // low split of a cross component
  localparam int D_W  = 103;         // det and numerators, room for negation
  localparam int QUO_BITS = 31;      // magnitude bits of the distance
  localparam int DV_W = D_W + QUO_BITS + 1;

  localparam int GEOM_LAT = 8;
  localparam int DIV_LAT  = QUO_BITS + 1;
  localparam int HIT_LAT  = 2;
  localparam int PIPE_LAT = GEOM_LAT + DIV_LAT + HIT_LAT;

  localparam logic [15:0] TAG_MASK =
    (TAG_BITS >= 16) ? 16'hffff : 16'((33'd1 << TAG_BITS) - 33'd1);

  typedef enum logic [2:0] {
    CFG_ORIGIN_X    = 3'd0,
    CFG_ORIGIN_Y    = 3'd1,
    CFG_ORIGIN_Z    = 3'd2,
    CFG_DIRECTION_X = 3'd3,
    CFG_DIRECTION_Y = 3'd4,
    CFG_DIRECTION_Z = 3'd5,
    CFG_EPSILON     = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] vertex_a_x;
    logic signed [31:0] vertex_a_y;
    logic signed [31:0] vertex_a_z;
    logic signed [31:0] vertex_b_x;
    logic signed [31:0] vertex_b_y;
    logic signed [31:0] vertex_b_z;
    logic signed [31:0] vertex_c_x;
    logic signed [31:0] vertex_c_y;
    logic signed [31:0] vertex_c_z;
    logic [15:0]        face_tag;
  } tri_in_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] distance;
    logic signed [31:0] hit_x;
    logic signed [31:0] hit_y;
    logic signed [31:0] hit_z;
    logic [15:0]        result_tag;
  } hit_out_t;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] direction_x;
    logic signed [31:0] direction_y;
    logic signed [31:0] direction_z;
    logic [15:0]        epsilon;
  } cfg_t;

  typedef struct packed {
    logic           valid;
    logic           miss;
    logic [15:0]    tag;
    logic [D_W-1:0] det;
    logic [D_W-1:0] nt;
  } geo_out_t;

  typedef struct packed {
    logic                valid;
    logic                miss;
    logic                sat;
    logic [15:0]         tag;
    logic [QUO_BITS-1:0] quo;
  } quo_out_t;

endpackage

// File: src/ray_triangle_intersect.sv
// Moller-Trumbore ray/triangle test in signed Q16.16. Load the ray (origin,
// direction, epsilon) through the cfg port while no triangle is in flight,
// then stream triangles on start: one is taken every clock and busy is only
// high during reset. Each triangle gives exactly one result, strobed by done
// for a single cycle, after its transfer has passed every stage, in the order
// the triangles went in. The receiver cannot hold results off, so it must
// capture every done cycle. Latency is set mostly by the 32-stage restoring
// divider that forms the distance: an entry stage that scales the numerator
// and flags saturation, then one quotient bit per stage; the rest is the
// edge/cross/dot multiplier pipeline (8 stages) and the hit point multiply
// and clamp (2 stages). On a miss hit, distance and the hit point read zero;
// result_tag always carries the triangle's tag.
module ray_triangle_intersect (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  rti_pkg::tri_in_t  triangle,
  output logic              done,
  output rti_pkg::hit_out_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data
);
  import rti_pkg::*;

  cfg_t     cfg;
  geo_out_t geo;
  quo_out_t quo;

  assign busy      = rst;
  assign cfg_ready = !rst;

  // ray registers; reset gives a ray along +z from the origin
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.origin_x    <= '0;
      cfg.origin_y    <= '0;
      cfg.origin_z    <= '0;
      cfg.direction_x <= '0;
      cfg.direction_y <= '0;
      cfg.direction_z <= 32'sd65536;
      cfg.epsilon     <= 16'd7;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ORIGIN_X:    cfg.origin_x    <= cfg_data;
        CFG_ORIGIN_Y:    cfg.origin_y    <= cfg_data;
        CFG_ORIGIN_Z:    cfg.origin_z    <= cfg_data;
        CFG_DIRECTION_X: cfg.direction_x <= cfg_data;
        CFG_DIRECTION_Y: cfg.direction_y <= cfg_data;
        CFG_DIRECTION_Z: cfg.direction_z <= cfg_data;
        CFG_EPSILON:     cfg.epsilon     <= cfg_data[15:0];
        default:         ;
      endcase
    end
  end

  // edges, cross products, det and the u/v/t numerators, plus all rejections but the epsilon test on t
  rti_geom u_geom (
    .clk      (clk),
    .rst      (rst),
    .in_valid (start && !busy),
    .tri_in   (triangle),
    .cfg      (cfg),
    .geo      (geo)
  );

  // t = floor(nt * 2^F / det), saturated
  rti_div u_div (
    .clk (clk),
    .rst (rst),
    .geo (geo),
    .quo (quo)
  );

  // epsilon test on t, hit point, output register
  rti_hit u_hit (
    .clk    (clk),
    .rst    (rst),
    .quo    (quo),
    .cfg    (cfg),
    .done   (done),
    .result (result)
  );

  // one result per transfer, fixed latency
  a_latency: assert property (@(posedge clk) disable iff (rst)
    done == $past(start && !busy, PIPE_LAT))
    else $error("result strobe out of step with transfers");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    done && !result.hit |-> result.distance == '0 && result.hit_x == '0
                            && result.hit_y == '0 && result.hit_z == '0)
    else $error("miss carries nonzero payload");

  a_hit_beyond_eps: assert property (@(posedge clk) disable iff (rst)
    done && result.hit |-> result.distance > $signed({16'd0, cfg.epsilon}))
    else $error("hit at or below epsilon");

endmodule

// File: src/rti_geom.sv
module rti_geom (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  rti_pkg::tri_in_t  tri_in,
  input  rti_pkg::cfg_t     cfg,
  output rti_pkg::geo_out_t geo
);
  import rti_pkg::*;

  localparam int DOT_DET = 0;
  localparam int DOT_NU  = 1;
  localparam int DOT_NV  = 2;
  localparam int DOT_NT  = 3;
  localparam int HI_W    = P_W - LO_W;
  localparam int MLO_W   = E_W + LO_W + 1;
  localparam int MHI_W   = E_W + HI_W;

  logic signed [X_W-1:0] va [3];
  logic signed [X_W-1:0] vb [3];
  logic signed [X_W-1:0] vc [3];
  logic signed [X_W-1:0] org [3];
  logic signed [E_W-1:0] dir [3];

  // stage 1: edges and origin offset
  logic              v1;
  logic [15:0]       tag1;
  logic signed [E_W-1:0] e1_1 [3];
  logic signed [E_W-1:0] e2_1 [3];
  logic signed [E_W-1:0] s_1  [3];
  // stage 2: cross product terms
  logic              v2;
  logic [15:0]       tag2;
  logic signed [E_W-1:0]  e1_2 [3];
  logic signed [E_W-1:0]  e2_2 [3];
  logic signed [E_W-1:0]  s_2  [3];
  logic signed [PP_W-1:0] pa2 [3];
  logic signed [PP_W-1:0] pb2 [3];
  logic signed [PP_W-1:0] qa2 [3];
  logic signed [PP_W-1:0] qb2 [3];
  // stage 3: cross products
  logic              v3;
  logic [15:0]       tag3;
  logic signed [E_W-1:0] e1_3 [3];
  logic signed [E_W-1:0] e2_3 [3];
  logic signed [E_W-1:0] s_3  [3];
  logic signed [P_W-1:0] p3 [3];
  logic signed [P_W-1:0] q3 [3];
  // stage 4: split partial products
  logic signed [E_W-1:0] opa [4][3];
  logic signed [P_W-1:0] opb [4][3];
  logic              v4;
  logic [15:0]       tag4;
  logic signed [MLO_W-1:0] lo4 [4][3];
  logic signed [MHI_W-1:0] hi4 [4][3];
  // stage 5: dot terms
  logic              v5;
  logic [15:0]       tag5;
  logic signed [D_W-1:0] term5 [4][3];
  // stage 6: dot sums
  logic              v6;
  logic [15:0]       tag6;
  logic signed [D_W-1:0] sum6 [4];
  // stage 7: sign normalised
  logic              v7;
  logic [15:0]       tag7;
  logic signed [D_W-1:0] nrm7 [4];
  // stage 8 checks
  logic signed [D_W-1:0] lim;
  logic signed [D_W:0]   nuv;
  logic                  rej;

  always_comb begin
    va[0] = tri_in.vertex_a_x; va[1] = tri_in.vertex_a_y; va[2] = tri_in.vertex_a_z;
    vb[0] = tri_in.vertex_b_x; vb[1] = tri_in.vertex_b_y; vb[2] = tri_in.vertex_b_z;
    vc[0] = tri_in.vertex_c_x; vc[1] = tri_in.vertex_c_y; vc[2] = tri_in.vertex_c_z;
    org[0] = cfg.origin_x; org[1] = cfg.origin_y; org[2] = cfg.origin_z;
    dir[0] = E_W'(cfg.direction_x);
    dir[1] = E_W'(cfg.direction_y);
    dir[2] = E_W'(cfg.direction_z);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0; v3 <= 1'b0; v4 <= 1'b0;
      v5 <= 1'b0; v6 <= 1'b0; v7 <= 1'b0;
    end else begin
      v1 <= in_valid; v2 <= v1; v3 <= v2; v4 <= v3;
      v5 <= v4; v6 <= v5; v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    tag1 <= tri_in.face_tag;
    for (int i = 0; i < 3; i++) begin
      e1_1[i] <= E_W'(vb[i]) - E_W'(va[i]);
      e2_1[i] <= E_W'(vc[i]) - E_W'(va[i]);
      s_1[i]  <= E_W'(org[i]) - E_W'(va[i]);
    end
  end

  always_ff @(posedge clk) begin
    tag2 <= tag1;
    e1_2 <= e1_1; e2_2 <= e2_1; s_2 <= s_1;
    pa2[0] <= dir[1] * e2_1[2]; pb2[0] <= dir[2] * e2_1[1];
    pa2[1] <= dir[2] * e2_1[0]; pb2[1] <= dir[0] * e2_1[2];
    pa2[2] <= dir[0] * e2_1[1]; pb2[2] <= dir[1] * e2_1[0];
    qa2[0] <= s_1[1] * e1_1[2]; qb2[0] <= s_1[2] * e1_1[1];
    qa2[1] <= s_1[2] * e1_1[0]; qb2[1] <= s_1[0] * e1_1[2];
    qa2[2] <= s_1[0] * e1_1[1]; qb2[2] <= s_1[1] * e1_1[0];
  end

  always_ff @(posedge clk) begin
    tag3 <= tag2;
    e1_3 <= e1_2; e2_3 <= e2_2; s_3 <= s_2;
    for (int i = 0; i < 3; i++) begin
      p3[i] <= P_W'(pa2[i]) - P_W'(pb2[i]);
      q3[i] <= P_W'(qa2[i]) - P_W'(qb2[i]);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      opa[DOT_DET][i] = e1_3[i]; opb[DOT_DET][i] = p3[i];
      opa[DOT_NU][i]  = s_3[i];  opb[DOT_NU][i]  = p3[i];
      opa[DOT_NV][i]  = dir[i];  opb[DOT_NV][i]  = q3[i];
      opa[DOT_NT][i]  = e2_3[i]; opb[DOT_NT][i]  = q3[i];
    end
  end

  always_ff @(posedge clk) begin
    tag4 <= tag3;
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < 3; i++) begin
        lo4[k][i] <= opa[k][i] * $signed({1'b0, opb[k][i][LO_W-1:0]});
        hi4[k][i] <= opa[k][i] * $signed(opb[k][i][P_W-1:LO_W]);
      end
    end
  end

  always_ff @(posedge clk) begin
    tag5 <= tag4;
    for (int k = 0; k < 4; k++) begin
      for (int i = 0; i < 3; i++) begin
        term5[k][i] <= (D_W'(hi4[k][i]) <<< LO_W) + D_W'(lo4[k][i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    tag6 <= tag5;
    for (int k = 0; k < 4; k++) begin
      sum6[k] <= term5[k][0] + term5[k][1] + term5[k][2];
    end
  end

  always_ff @(posedge clk) begin
    tag7 <= tag6;
    for (int k = 0; k < 4; k++) begin
      nrm7[k] <= sum6[DOT_DET][D_W-1] ? -sum6[k] : sum6[k];
    end
  end

  always_comb begin
    lim = $signed(D_W'(cfg.epsilon)) <<< (2 * FRAC_BITS);
    nuv = (D_W + 1)'(nrm7[DOT_NU]) + (D_W + 1)'(nrm7[DOT_NV]);
    rej = (nrm7[DOT_DET] == '0) || (nrm7[DOT_DET] < lim)
       || nrm7[DOT_NU][D_W-1] || (nrm7[DOT_NU] > nrm7[DOT_DET])
       || nrm7[DOT_NV][D_W-1] || (nuv > (D_W + 1)'(nrm7[DOT_DET]))
       || nrm7[DOT_NT][D_W-1] || (nrm7[DOT_NT] == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      geo.valid <= 1'b0;
    end else begin
      geo.valid <= v7;
    end
    geo.miss <= rej;
    geo.tag  <= tag7;
    geo.det  <= nrm7[DOT_DET];
    geo.nt   <= nrm7[DOT_NT];
  end

endmodule

// File: src/rti_div.sv
module rti_div (
  input  logic              clk,
  input  logic              rst,
  input  rti_pkg::geo_out_t geo,
  output rti_pkg::quo_out_t quo
);
  import rti_pkg::*;

  typedef struct packed {
    logic                valid;
    logic                miss;
    logic                sat;
    logic [15:0]         tag;
    logic [D_W-1:0]      det;
    logic [DV_W-1:0]     rem;
    logic [QUO_BITS-1:0] quo;
  } div_stage_t;

  div_stage_t st [QUO_BITS+1];
  logic [DV_W-1:0] num;

  // entry: scale numerator, detect overflow of the quotient
  always_comb num = DV_W'(geo.nt) << FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      st[0].valid <= 1'b0;
    end else begin
      st[0].valid <= geo.valid;
    end
    st[0].miss <= geo.miss;
    st[0].sat  <= num >= (DV_W'(geo.det) << QUO_BITS);
    st[0].tag  <= geo.tag;
    st[0].det  <= geo.det;
    st[0].rem  <= num;
    st[0].quo  <= '0;
  end

  for (genvar k = 0; k < QUO_BITS; k++) begin : g_step
    localparam int B = QUO_BITS - 1 - k;
    logic [DV_W-1:0]     sub;
    logic                ge;
    logic [QUO_BITS-1:0] quo_next;

    always_comb begin
      sub      = DV_W'(st[k].det) << B;
      ge       = st[k].rem >= sub;
      quo_next = st[k].quo;
      quo_next[B] = ge;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st[k+1].valid <= 1'b0;
      end else begin
        st[k+1].valid <= st[k].valid;
      end
      st[k+1].miss <= st[k].miss;
      st[k+1].sat  <= st[k].sat;
      st[k+1].tag  <= st[k].tag;
      st[k+1].det  <= st[k].det;
      st[k+1].rem  <= ge ? st[k].rem - sub : st[k].rem;
      st[k+1].quo  <= quo_next;
    end
  end

  always_comb begin
    quo.valid = st[QUO_BITS].valid;
    quo.miss  = st[QUO_BITS].miss;
    quo.sat   = st[QUO_BITS].sat;
    quo.tag   = st[QUO_BITS].tag;
    quo.quo   = st[QUO_BITS].quo;
  end

endmodule

// File: src/rti_hit.sv
module rti_hit (
  input  logic              clk,
  input  logic              rst,
  input  rti_pkg::quo_out_t quo,
  input  rti_pkg::cfg_t     cfg,
  output logic              done,
  output rti_pkg::hit_out_t result
);
  import rti_pkg::*;

  localparam int V_W = 2 * X_W + 1;

  logic [X_W-1:0]        t;
  logic                  v1;
  logic                  miss1;
  logic [15:0]           tag1;
  logic signed [X_W-1:0] t1;
  logic signed [2*X_W-1:0] prod1 [3];
  logic signed [X_W-1:0] org [3];
  logic signed [X_W-1:0] dir [3];
  logic signed [V_W-1:0] v [3];
  logic signed [X_W-1:0] coord [3];

  always_comb begin
    t = quo.sat ? {1'b0, {(X_W-1){1'b1}}} : X_W'(quo.quo);
    org[0] = cfg.origin_x;    org[1] = cfg.origin_y;    org[2] = cfg.origin_z;
    dir[0] = cfg.direction_x; dir[1] = cfg.direction_y; dir[2] = cfg.direction_z;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= quo.valid;
    end
    miss1 <= quo.miss || (t <= X_W'(cfg.epsilon));
    tag1  <= quo.tag;
    t1    <= $signed(t);
    for (int i = 0; i < 3; i++) begin
      prod1[i] <= dir[i] * $signed(t);
    end
  end

  // floor by arithmetic shift, then clamp to 32 bits
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      v[i] = ((V_W'(org[i]) <<< FRAC_BITS) + V_W'(prod1[i])) >>> FRAC_BITS;
      if (v[i] > V_W'(32'sh7fffffff)) begin
        coord[i] = 32'sh7fffffff;
      end else if (v[i] < -(V_W'(33'sh080000000))) begin
        coord[i] = 32'sh80000000;
      end else begin
        coord[i] = X_W'(v[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= v1;
    end
    result.hit        <= !miss1;
    result.distance   <= miss1 ? '0 : t1;
    result.hit_x      <= miss1 ? '0 : coord[0];
    result.hit_y      <= miss1 ? '0 : coord[1];
    result.hit_z      <= miss1 ? '0 : coord[2];
    result.result_tag <= tag1 & TAG_MASK;
  end

endmodule
